>>> rtl/fbw_pkg.sv
// fbw_pkg: shared types, constants and helpers for the backward flow warp.
// No dependencies.
package fbw_pkg;

  localparam int FRAC    = 6;
  localparam int COORD_W = 8;
  localparam int POS_W   = COORD_W + FRAC;
  localparam int DIM_W   = 9;
  localparam int NCH     = 4;
  localparam int CH_W    = 8;
  localparam int FLOW_W  = 16;
  localparam int MAX_DIM = 256;
  localparam int NCH_W   = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 2;
  localparam int BANKS   = 4;
  localparam int BANK_AW = 2 * (COORD_W - 1);
  localparam int PIX_W   = NCH * CH_W;

  localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd2;
  localparam logic [IDX_W-1:0] REG_MODE     = 2'd3;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BILINEAR = 2'd0,
    MODE_NEAREST  = 2'd1,
    MODE_NONE     = 2'd2
  } interp_mode_t;

  typedef struct packed {
    req_kind_t                    kind;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic [POS_W-1:0]             py;
    logic [POS_W-1:0]             px;
    logic [NCH-1:0][CH_W-1:0]     pix;
  } fbw_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [NCH_W-1:0] nch;
    logic [MODE_W-1:0] mode;
  } fbw_cfg_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(2)) r = DIM_W'(2);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/fbw_req_if.sv
// fbw_req_if: request channel (loads and warp queries).
// Depends on fbw_pkg.
interface fbw_req_if;
  import fbw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [COORD_W-1:0]       row;
  logic [COORD_W-1:0]       col;
  logic [CH_W-1:0]          pixel_c0;
  logic [CH_W-1:0]          pixel_c1;
  logic [CH_W-1:0]          pixel_c2;
  logic [CH_W-1:0]          pixel_c3;
  logic signed [FLOW_W-1:0] flow_y;
  logic signed [FLOW_W-1:0] flow_col;

  modport source (output valid, req_type, row, col, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                  flow_y, flow_col, input ready);
  modport sink (input valid, req_type, row, col, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                flow_y, flow_col, output ready);
endinterface

>>> rtl/fbw_res_if.sv
// fbw_res_if: result channel (warped pixels).
// Depends on fbw_pkg.
interface fbw_res_if;
  import fbw_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [CH_W-1:0]    value_c0;
  logic [CH_W-1:0]    value_c1;
  logic [CH_W-1:0]    value_c2;
  logic [CH_W-1:0]    value_c3;
  logic               written;

  modport source (output valid, out_row, out_col, value_c0, value_c1, value_c2, value_c3,
                  written, input ready);
  modport sink (input valid, out_row, out_col, value_c0, value_c1, value_c2, value_c3,
                written, output ready);
endinterface

>>> rtl/fbw_ram.sv
// fbw_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module fbw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> rtl/fbw_front.sv
// fbw_front: accepts request beats, computes clamped fixed-point targets.
// Depends on fbw_pkg, fbw_req_if.
module fbw_front (
  input  logic             clk,
  input  logic             rst,
  fbw_req_if.sink          req,
  input  fbw_pkg::fbw_cfg_t cfg,
  output fbw_pkg::fbw_item_t item,
  output logic             item_valid,
  input  logic             item_ready
);
  import fbw_pkg::*;

  localparam int SUM_W = POS_W + 3;

  function automatic logic [POS_W-1:0] target(input logic [COORD_W-1:0] base,
                                              input logic [FLOW_W-1:0] flow,
                                              input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0]        szm1;
    logic [POS_W-1:0]        top;
    logic signed [SUM_W-1:0] pos;
    logic [POS_W-1:0]        r;
    szm1 = size - 1'b1;
    top  = {szm1[COORD_W-1:0], {FRAC{1'b0}}} - 1'b1;
    pos  = $signed({3'b000, base, {FRAC{1'b0}}})
         + $signed({{(SUM_W-FLOW_W){flow[FLOW_W-1]}}, flow});
    if (pos < 0) r = '0;
    else if (pos > $signed({3'b000, top})) r = top;
    else r = pos[POS_W-1:0];
    return r;
  endfunction

  logic held;

  assign req.ready  = !held || item_ready;
  assign item_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.ready) begin
      held <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.kind <= req_kind_t'(req.req_type);
      item.row  <= req.row;
      item.col  <= req.col;
      item.py   <= target(req.row, req.flow_y, cfg.height);
      item.px   <= target(req.col, req.flow_col, cfg.width);
      item.pix  <= {req.pixel_c3, req.pixel_c2, req.pixel_c1, req.pixel_c0};
    end
  end
endmodule

>>> rtl/fbw_queue.sv
// fbw_queue: small flop FIFO between front and back.
// Depends on fbw_pkg.
module fbw_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  fbw_pkg::fbw_item_t in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output fbw_pkg::fbw_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import fbw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fbw_item_t       slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_item;
  end
endmodule

>>> rtl/fbw_back.sv
// fbw_back: banked frame store, neighbour fetch, bilinear/nearest blend, output register.
// Depends on fbw_pkg, fbw_res_if, fbw_ram.
module fbw_back (
  input  logic               clk,
  input  logic               rst,
  input  fbw_pkg::fbw_item_t item,
  input  logic               item_valid,
  output logic               item_ready,
  input  fbw_pkg::fbw_cfg_t  cfg,
  fbw_res_if.source          res
);
  import fbw_pkg::*;

  localparam int W_W   = FRAC + 1;
  localparam int UP_W  = FRAC + CH_W;
  localparam int MIX_W = 2 * FRAC + CH_W + 1;
  localparam logic [W_W-1:0] ONE  = W_W'(1) << FRAC;
  localparam logic [POS_W:0] HALF = (POS_W + 1)'(1) << (FRAC - 1);

  logic adv;
  logic issue;
  logic [COORD_W-1:0] y0, x0, y1, x1, ry, rx;
  logic [POS_W:0]     ry_sum, rx_sum;
  logic [PIX_W-1:0]   rdata [BANKS];

  assign adv        = !res.valid || res.ready;
  assign item_ready = adv;
  assign issue      = item_valid && adv;

  assign y0     = item.py[POS_W-1:FRAC];
  assign x0     = item.px[POS_W-1:FRAC];
  assign y1     = y0 + 1'b1;
  assign x1     = x0 + 1'b1;
  assign ry_sum = {1'b0, item.py} + HALF;
  assign rx_sum = {1'b0, item.px} + HALF;
  assign ry     = ry_sum[POS_W-1:FRAC];
  assign rx     = rx_sum[POS_W-1:FRAC];

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);
    logic [COORD_W-1:0] rsel, csel;
    logic               we;
    assign rsel = (cfg.mode == MODE_NEAREST) ? ry : ((y0[0] == RP) ? y0 : y1);
    assign csel = (cfg.mode == MODE_NEAREST) ? rx : ((x0[0] == CP) ? x0 : x1);
    assign we   = issue && item.kind == REQ_LOAD && item.row[0] == RP && item.col[0] == CP;
    fbw_ram #(.WIDTH(PIX_W), .DEPTH(1 << BANK_AW)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr ({item.row[COORD_W-1:1], item.col[COORD_W-1:1]}),
      .wdata (item.pix),
      .re    (adv),
      .raddr ({rsel[COORD_W-1:1], csel[COORD_W-1:1]}),
      .rdata (rdata[b])
    );
  end

  // stage a: RAM read in flight
  logic               a_valid, a_yp, a_xp;
  logic [COORD_W-1:0] a_row, a_col;
  logic [FRAC-1:0]    a_fy, a_fx;
  logic [MODE_W-1:0]  a_mode;
  logic [NCH_W-1:0]   a_nch;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= item_valid && item.kind == REQ_QUERY;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_row  <= item.row;
      a_col  <= item.col;
      a_fy   <= item.py[FRAC-1:0];
      a_fx   <= item.px[FRAC-1:0];
      a_yp   <= (cfg.mode == MODE_NEAREST) ? ry[0] : y0[0];
      a_xp   <= (cfg.mode == MODE_NEAREST) ? rx[0] : x0[0];
      a_mode <= cfg.mode;
      a_nch  <= cfg.nch;
    end
  end

  logic [NCH-1:0][CH_W-1:0] q1, q2, q3, q4;
  logic [NCH-1:0][UP_W-1:0] up, dn;
  logic [W_W-1:0]           wx0, wx1;

  assign q1  = rdata[{a_yp, a_xp}];
  assign q2  = rdata[{a_yp, !a_xp}];
  assign q3  = rdata[{!a_yp, a_xp}];
  assign q4  = rdata[{!a_yp, !a_xp}];
  assign wx1 = {1'b0, a_fx};
  assign wx0 = ONE - wx1;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      up[c] = UP_W'(wx0) * UP_W'(q1[c]) + UP_W'(wx1) * UP_W'(q2[c]);
      dn[c] = UP_W'(wx0) * UP_W'(q3[c]) + UP_W'(wx1) * UP_W'(q4[c]);
    end
  end

  // stage b: horizontal blends
  logic                     b_valid;
  logic [COORD_W-1:0]       b_row, b_col;
  logic [FRAC-1:0]          b_fy;
  logic [MODE_W-1:0]        b_mode;
  logic [NCH_W-1:0]         b_nch;
  logic [NCH-1:0][UP_W-1:0] b_up, b_dn;
  logic [NCH-1:0][CH_W-1:0] b_near;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_row  <= a_row;
      b_col  <= a_col;
      b_fy   <= a_fy;
      b_mode <= a_mode;
      b_nch  <= a_nch;
      b_up   <= up;
      b_dn   <= dn;
      b_near <= q1;
    end
  end

  logic [W_W-1:0]           wy0, wy1;
  logic [MIX_W-1:0]         mix [NCH];
  logic [NCH-1:0][CH_W-1:0] val;
  logic                     wr;

  assign wy1 = {1'b0, b_fy};
  assign wy0 = ONE - wy1;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mix[c] = MIX_W'(wy0) * MIX_W'(b_up[c]) + MIX_W'(wy1) * MIX_W'(b_dn[c]);
    end
    wr = 1'b0;
    for (int c = 0; c < NCH; c++) val[c] = '0;
    unique case (b_mode)
      MODE_BILINEAR: begin
        wr = 1'b1;
        for (int c = 0; c < NCH; c++) val[c] = mix[c][2*FRAC+CH_W-1:2*FRAC];
      end
      MODE_NEAREST: begin
        wr = 1'b1;
        for (int c = 0; c < NCH; c++) val[c] = b_near[c];
      end
      default: wr = 1'b0;
    endcase
    for (int c = 0; c < NCH; c++) begin
      if (NCH_W'(c) >= b_nch) val[c] = '0;
    end
  end

  // output register
  logic                     o_valid;
  logic [NCH-1:0][CH_W-1:0] o_val;

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (adv) o_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.out_row <= b_row;
      res.out_col <= b_col;
      res.written <= wr;
      o_val       <= val;
    end
  end

  assign res.valid    = o_valid;
  assign res.value_c0 = o_val[0];
  assign res.value_c1 = o_val[1];
  assign res.value_c2 = o_val[2];
  assign res.value_c3 = o_val[3];

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !res.written |-> o_val == '0)
    else $error("unwritten result carries nonzero values");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !o_valid && !a_valid && !b_valid)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv |=> a_valid && $stable(a_row) && $stable(a_col))
    else $error("read stage lost its beat during stall");
endmodule

>>> rtl/flow_backward_warp.sv
// flow_backward_warp: top level of the backward flow warp.
// Depends on fbw_pkg, fbw_req_if, fbw_res_if, fbw_front, fbw_queue, fbw_back.
//
// Usage:
//   req channel: each beat is a load (req_type 0) writing one 4-channel pixel
//   at (row, col), or a query (req_type 1) naming an output pixel and a flow
//   vector with 6 fraction bits. Loads give no result; every query gives one
//   beat on the res channel, in request order.
//   cfg port: cfg_we/cfg_index/cfg_data write height, width, channel count and
//   interpolation mode; write only while the block is idle.
//   Throughput: one beat per cycle while the output does not stall. The frame
//   store is split into four banks by row and column parity, so the four
//   bilinear neighbours are read in parallel.
//   Pipeline from request accept to result valid: front register, queue, RAM
//   read, horizontal blend, output register.
//   Stall: a waiting result with res.ready low holds the back pipeline; the
//   front and queue take beats until the queue fills, then req.ready drops.
//   Reset (rst, synchronous): empties the pipeline, config returns to
//   256 x 256, 3 channels, bilinear. Frame contents are not cleared; every
//   pixel must be loaded before a query reads it.
module flow_backward_warp #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  fbw_req_if.sink                    req,
  fbw_res_if.source                  res,
  input  logic                       cfg_we,
  input  logic [fbw_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fbw_pkg::CFG_W-1:0]  cfg_data
);
  import fbw_pkg::*;

  logic [DIM_W-1:0]  height;
  logic [DIM_W-1:0]  width;
  logic [NCH_W-1:0]  channels;
  logic [MODE_W-1:0] mode;
  fbw_cfg_t          cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      height   <= DIM_W'(MAX_DIM);
      width    <= DIM_W'(MAX_DIM);
      channels <= NCH_W'(3);
      mode     <= MODE_BILINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT:   height   <= cfg_data[DIM_W-1:0];
        REG_WIDTH:    width    <= cfg_data[DIM_W-1:0];
        REG_CHANNELS: channels <= cfg_data[NCH_W-1:0];
        REG_MODE:     mode     <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.height = sat_dim(height);
    cfg.width  = sat_dim(width);
    cfg.nch    = (channels > NCH_W'(NCH)) ? NCH_W'(NCH) : channels;
    cfg.mode   = mode;
  end

  fbw_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_ready;

  fbw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  fbw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_item   (f_item),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_item  (q_item),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  fbw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .cfg        (cfg),
    .res        (res)
  );
endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for flow_backward_warp (loads, bilinear and nearest warps).
// Depends on fbw_pkg, fbw_req_if, fbw_res_if and the flow_backward_warp RTL.
// A local warp predictor checks every result beat in order under random idling and stalls.
module tb_top;
  import fbw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] val [4];
    logic       written;
  } warp_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  fbw_req_if req ();
  fbw_res_if res ();

  flow_backward_warp dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] frame_mem [65536];
  logic [8:0] m_height = 9'd256, m_width = 9'd256;
  logic [2:0] m_nch = 3'd3;
  logic [1:0] m_mode = 2'd0;
  warp_px_t warped_q [$];
  int mismatches = 0;
  int burst_left = 0;

  function automatic int eff_dim(input logic [8:0] v);
    int d;
    d = v;
    if (d < 2) d = 2;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  function automatic int clamp_target(input logic [7:0] base, input logic signed [15:0] flow,
                                      input int size);
    int p, top;
    p = (int'(base) <<< FRAC) + int'(flow);
    top = ((size - 1) <<< FRAC) - 1;
    if (p < 0) p = 0;
    if (p > top) p = top;
    return p;
  endfunction

  function automatic logic [7:0] chan(input int r, input int c, input int k);
    logic [31:0] w;
    w = frame_mem[(r % 256) * 256 + (c % 256)];
    return w[8*k +: 8];
  endfunction

  function automatic warp_px_t predict_warp(input logic [7:0] row, input logic [7:0] col,
                                            input logic signed [15:0] fr,
                                            input logic signed [15:0] fc);
    warp_px_t o;
    int h, w, n, py, px, fy, fx, y0, x0, y1, x1, up, dn, v, ry, rx;
    h = eff_dim(m_height);
    w = eff_dim(m_width);
    n = (m_nch > 4) ? 4 : m_nch;
    py = clamp_target(row, fr, h);
    px = clamp_target(col, fc, w);
    o.row = row;
    o.col = col;
    o.written = 1'b0;
    for (int k = 0; k < 4; k++) o.val[k] = 8'd0;
    if (m_mode == MODE_BILINEAR) begin
      fy = py & 63; fx = px & 63;
      y0 = py >> FRAC; x0 = px >> FRAC;
      y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
      x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
      for (int k = 0; k < n; k++) begin
        up = (64 - fx) * chan(y0, x0, k) + fx * chan(y0, x1, k);
        dn = (64 - fx) * chan(y1, x0, k) + fx * chan(y1, x1, k);
        v = ((64 - fy) * up + fy * dn) >> (2 * FRAC);
        o.val[k] = (v > 255) ? 8'd255 : v[7:0];
      end
      o.written = 1'b1;
    end else if (m_mode == MODE_NEAREST) begin
      ry = (py + 32) >> FRAC;
      rx = (px + 32) >> FRAC;
      for (int k = 0; k < n; k++) o.val[k] = chan(ry, rx, k);
      o.written = 1'b1;
    end
    return o;
  endfunction

  // sender: bursts with random gaps; inputs change on the falling edge
  task automatic send_beat(input req_kind_t kind, input logic [7:0] row, input logic [7:0] col,
                           input logic [31:0] pix, input logic signed [15:0] fr,
                           input logic signed [15:0] fc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid = 1'b1;
    req.req_type = kind;
    req.row = row;
    req.col = col;
    {req.pixel_c3, req.pixel_c2, req.pixel_c1, req.pixel_c0} = pix;
    req.flow_y = fr;
    req.flow_col = fc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (kind == REQ_LOAD) frame_mem[int'(row) * 256 + int'(col)] = pix;
    else warped_q.push_back(predict_warp(row, col, fr, fc));
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic wait_idle();
    req.valid = 1'b0;
    while (warped_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HEIGHT:   m_height = data;
      REG_WIDTH:    m_width = data;
      REG_CHANNELS: m_nch = data[2:0];
      default:      m_mode = data[1:0];
    endcase
  endtask

  task automatic set_config(input int h, input int w, input int n, input logic [1:0] mode);
    wait_idle();
    write_reg(REG_HEIGHT, h[8:0]);
    write_reg(REG_WIDTH, w[8:0]);
    write_reg(REG_CHANNELS, n[8:0]);
    write_reg(REG_MODE, {7'd0, mode});
  endtask

  // every pixel a query can reach is loaded before any query of the phase
  task automatic load_region();
    for (int r = 0; r < eff_dim(m_height); r++)
      for (int c = 0; c < eff_dim(m_width); c++)
        send_beat(REQ_LOAD, r[7:0], c[7:0], $urandom, 16'sd0, 16'sd0);
  endtask

  task automatic send_query(input logic [7:0] row, input logic [7:0] col,
                            input logic signed [15:0] fr, input logic signed [15:0] fc);
    send_beat(REQ_QUERY, row, col, $urandom, fr, fc);
  endtask

  task automatic random_query();
    logic [7:0] r, c;
    logic signed [15:0] fr, fc;
    r = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, eff_dim(m_height) - 1));
    c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, eff_dim(m_width) - 1));
    fr = ($urandom_range(0, 2) == 0) ? $signed(16'($urandom))
                                     : $signed(16'($urandom_range(0, 1023)) - 16'd512);
    fc = ($urandom_range(0, 2) == 0) ? $signed(16'($urandom))
                                     : $signed(16'($urandom_range(0, 1023)) - 16'd512);
    send_query(r, c, fr, fc);
  endtask

  task automatic random_beats(input int count, input logic bool_pause);
    for (int i = 0; i < count; i++) begin
      if (bool_pause && i == count / 2) wait_idle();
      if ($urandom_range(0, 4) == 0)
        send_beat(REQ_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                  $signed(16'($urandom)), $signed(16'($urandom)));
      else
        random_query();
    end
  endtask

  task automatic test_bilinear_edges();
    set_config(0, 511, 4, MODE_BILINEAR);
    load_region();
    send_query(8'd0, 8'd0, 16'sd0, 16'sd0);
    send_query(8'd255, 8'd255, 16'sh7fff, 16'sh7fff);
    send_query(8'd0, 8'd0, -16'sd32768, -16'sd32768);
    send_query(8'd0, 8'd100, 16'sd32, 16'sd31);
    send_query(8'd1, 8'd254, -16'sd1, 16'sd63);
    send_query(8'd0, 8'd128, 16'sd63, -16'sd64);
    send_query(8'd0, 8'd255, 16'sd0, 16'sd0);
    send_query(8'd255, 8'd0, -16'sd16000, 16'sd12345);
    random_beats(40, 1'b0);
  endtask

  task automatic test_nearest_edges();
    set_config(300, 1, 7, MODE_NEAREST);
    load_region();
    send_query(8'd0, 8'd0, 16'sd31, 16'sd32);
    send_query(8'd100, 8'd1, 16'sd32, 16'sd31);
    send_query(8'd255, 8'd255, 16'sh7fff, -16'sd32768);
    send_query(8'd0, 8'd0, -16'sd32768, 16'sh7fff);
    send_query(8'd254, 8'd0, 16'sd63, 16'sd0);
    random_beats(40, 1'b0);
  endtask

  task automatic test_mode_none_and_unused();
    set_config(8, 8, 0, MODE_NONE);
    load_region();
    send_query(8'd3, 8'd4, 16'sd100, -16'sd100);
    random_beats(20, 1'b0);
    set_config(5, 13, 1, MODE_UNUSED);
    load_region();
    send_query(8'd200, 8'd7, 16'sd0, 16'sd5);
    random_beats(20, 1'b0);
    set_config(5, 13, 0, MODE_BILINEAR);
    random_beats(20, 1'b0);
  endtask

  task automatic test_random_phases();
    int mode;
    for (int ph = 0; ph < 4; ph++) begin
      mode = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
      set_config($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 7), mode[1:0]);
      load_region();
      random_beats(100, ph == 2);
    end
  endtask

  // receiver: alternating stretches of no stall, random stall and a fixed pattern
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0: res.ready <= 1'b1;
      1: res.ready <= ($urandom_range(0, 9) < 6);
      default: res.ready <= (rx_cycle % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    warp_px_t e;
    bit bad;
    if (!rst && res.valid && res.ready) begin
      if (warped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat row %0d col %0d",
                                       res.out_row, res.out_col);
      end else begin
        e = warped_q.pop_front();
        bad = (res.out_row !== e.row) || (res.out_col !== e.col) ||
              (res.value_c0 !== e.val[0]) || (res.value_c1 !== e.val[1]) ||
              (res.value_c2 !== e.val[2]) || (res.value_c3 !== e.val[3]) ||
              (res.written !== e.written);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r%0d c%0d v %h %h %h %h w%b got r%0d c%0d v %h %h %h %h w%b",
                     e.row, e.col, e.val[0], e.val[1], e.val[2], e.val[3], e.written,
                     res.out_row, res.out_col, res.value_c0, res.value_c1, res.value_c2,
                     res.value_c3, res.written);
        end
      end
    end
  end

  initial begin
    #(12 * 2000000);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int waited;
    req.valid = 1'b0;
    req.req_type = REQ_LOAD;
    req.row = '0;
    req.col = '0;
    req.pixel_c0 = '0;
    req.pixel_c1 = '0;
    req.pixel_c2 = '0;
    req.pixel_c3 = '0;
    req.flow_y = '0;
    req.flow_col = '0;
    res.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_bilinear_edges();
    test_nearest_edges();
    test_mode_none_and_unused();
    test_random_phases();
    waited = 0;
    while (warped_q.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && warped_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fbw_pkg.sv
rtl/fbw_req_if.sv
rtl/fbw_res_if.sv
rtl/fbw_ram.sv
rtl/fbw_front.sv
rtl/fbw_queue.sv
rtl/fbw_back.sv
rtl/flow_backward_warp.sv
verif/tb_top.sv
